// ===== src/tccw_pkg.sv =====
// Shared types, constants and microcode encoding of the text console cell writer.
`default_nettype none

package tccw_pkg;

  // Screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CELL_W = 16;

  // Character codes
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_BLANK_CODE = 8'h08;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_ERROR      = 8'h45;

  // Configuration registers
  localparam int          APB_AW           = 3;
  localparam logic [7:0]  DEFAULT_ATTR_RST = 8'd15;
  localparam logic [7:0]  ERROR_ATTR_RST   = 8'd244;
  localparam logic        REG_DEFAULT_ATTR = 1'b0;
  localparam logic        REG_ERROR_ATTR   = 1'b1;

  typedef enum logic [2:0] {
    OP_PUT_CUR = 3'd0,
    OP_PUT_AT  = 3'd1,
    OP_BACK    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [5:0] row;
    logic [7:0] attr;
  } cmd_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic       pos_error;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } res_t;

  typedef struct packed {
    logic [7:0] default_attr;
    logic [7:0] error_attr;
  } cfg_t;

  // Microprogram steps
  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_PUT, S_SC1, S_SC2, S_SC3, S_SC4,
    S_ERR, S_BS, S_BS2, S_CLR, S_RD, S_NOP
  } step_t;

  typedef enum logic [2:0] {A_POS, A_CUR, A_LAST, A_CNT, A_CNT_M1} addr_sel_t;
  typedef enum logic [2:0] {D_ZERO, D_PUT, D_BLANK, D_ERR, D_COPY} data_sel_t;
  typedef enum logic [1:0] {R_NONE, R_POS, R_SCROLL} rd_sel_t;
  typedef enum logic [1:0] {CU_HOLD, CU_PUT, CU_BACK, CU_ZERO} cur_op_t;
  typedef enum logic      {N_HOLD, N_INC} cnt_op_t;
  typedef enum logic [1:0] {J_NONE, J_WRAP, J_MORE_COPY, J_MORE_CELLS} cond_t;

  // One control word
  typedef struct packed {
    addr_sel_t addr;
    data_sel_t data;
    logic      wr;
    rd_sel_t   rd;
    cur_op_t   cur;
    cnt_op_t   cnt;
    cond_t     cond;
    step_t     target;
    step_t     nxt;
    logic      res;
  } ucode_t;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic wrap;
    logic more_copy;
    logic more_cells;
  } flags_t;

endpackage

`default_nettype wire

// ===== src/tccw_cfg.sv =====
// APB register file holding the default and error attributes.
`default_nettype none

module tccw_cfg import tccw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_beat;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_beat = psel & penable & pwrite & pready;

  // Update registers on a write beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_attr <= DEFAULT_ATTR_RST;
      cfg.error_attr   <= ERROR_ATTR_RST;
    end else if (wr_beat) begin
      unique case (reg_sel)
        REG_DEFAULT_ATTR: cfg.default_attr <= pwdata[7:0];
        REG_ERROR_ATTR:   cfg.error_attr   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Return the selected register
  always_comb begin
    unique case (reg_sel)
      REG_DEFAULT_ATTR: prdata = {24'd0, cfg.default_attr};
      REG_ERROR_ATTR:   prdata = {24'd0, cfg.error_attr};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tccw_store.sv =====
// Cell memory: one write port and one registered read port.
`default_nettype none

module tccw_store import tccw_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tccw_seq.sv =====
// Microcode sequencer: step register, control ROM and jump logic.
`default_nettype none

module tccw_seq import tccw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] op,
  input  logic       pos_ok,
  input  flags_t     flags,
  output ucode_t     uc,
  output logic       busy,
  output logic       done
);

  step_t step;
  step_t step_next;
  logic  jump;
  logic  done_next;

  // Control store
  function automatic ucode_t rom(step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      S_IDLE: ;
      S_INIT: begin
        w.addr = A_CNT;   w.data = D_ZERO;  w.wr = 1'b1; w.cnt = N_INC;
        w.cond = J_MORE_CELLS; w.target = S_INIT; w.nxt = S_IDLE;
      end
      S_PUT: begin
        w.addr = A_POS;   w.data = D_PUT;   w.wr = 1'b1; w.cur = CU_PUT;
        w.cond = J_WRAP;  w.target = S_SC1; w.nxt = S_IDLE; w.res = 1'b1;
      end
      S_SC1: begin
        w.rd = R_SCROLL;  w.cnt = N_INC;    w.nxt = S_SC2;
      end
      S_SC2: begin
        w.addr = A_CNT_M1; w.data = D_COPY; w.wr = 1'b1; w.rd = R_SCROLL;
        w.cnt = N_INC; w.cond = J_MORE_COPY; w.target = S_SC2; w.nxt = S_SC3;
      end
      S_SC3: begin
        w.addr = A_CNT_M1; w.data = D_COPY; w.wr = 1'b1; w.nxt = S_SC4;
      end
      S_SC4: begin
        w.addr = A_CNT;   w.data = D_BLANK; w.wr = 1'b1; w.cnt = N_INC;
        w.cond = J_MORE_CELLS; w.target = S_SC4; w.nxt = S_IDLE; w.res = 1'b1;
      end
      S_ERR: begin
        w.addr = A_LAST;  w.data = D_ERR;   w.wr = 1'b1;
        w.nxt = S_IDLE;   w.res = 1'b1;
      end
      S_BS: begin
        w.cur = CU_BACK;  w.nxt = S_BS2;
      end
      S_BS2: begin
        w.addr = A_CUR;   w.data = D_BLANK; w.wr = 1'b1;
        w.nxt = S_IDLE;   w.res = 1'b1;
      end
      S_CLR: begin
        w.addr = A_CNT;   w.data = D_BLANK; w.wr = 1'b1; w.cnt = N_INC;
        w.cur = CU_ZERO;  w.cond = J_MORE_CELLS; w.target = S_CLR;
        w.nxt = S_IDLE;   w.res = 1'b1;
      end
      S_RD: begin
        w.rd = R_POS;     w.nxt = S_IDLE;   w.res = 1'b1;
      end
      S_NOP: begin
        w.nxt = S_IDLE;   w.res = 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Entry point of each command
  function automatic step_t entry(logic [2:0] code, logic in_range);
    step_t e;
    e = S_NOP;
    case (code)
      OP_PUT_CUR: e = S_PUT;
      OP_PUT_AT:  e = in_range ? S_PUT : S_ERR;
      OP_BACK:    e = S_BS;
      OP_CLEAR:   e = S_CLR;
      OP_READ:    e = in_range ? S_RD : S_NOP;
      default:    e = S_NOP;
    endcase
    return e;
  endfunction

  // Fetch the control word and evaluate its jump condition
  always_comb begin
    uc = rom(step);
    unique case (uc.cond)
      J_NONE:       jump = 1'b0;
      J_WRAP:       jump = flags.wrap;
      J_MORE_COPY:  jump = flags.more_copy;
      J_MORE_CELLS: jump = flags.more_cells;
      default:      jump = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (step == S_IDLE) begin
      step_next = accept ? entry(op, pos_ok) : S_IDLE;
    end else begin
      step_next = jump ? uc.target : uc.nxt;
    end
  end

  // Status outputs
  always_comb begin
    busy      = (step != S_IDLE);
    done_next = busy & uc.res & (step_next == S_IDLE);
  end

  // Advance
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_INIT;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= done_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/text_console_cell_writer_top.sv =====
// Top level of the text console cell writer: command datapath and cell store.
`default_nettype none

// An 80 x 25 text screen of character/attribute cells with a cursor. A command
// is taken when start is high and busy is low; its result appears on result
// for one cycle with done high, and must be taken then. The next command may
// start in the cycle that carries the previous result. A put that takes the
// cursor past the last row scrolls the screen, and clear holds busy while it
// blanks every cell. After reset the store is swept to zero with busy high;
// configuration writes are taken meanwhile. These sweeps go cell by cell, as
// the single write port of the cell store takes one cell per cycle.
module text_console_cell_writer_top import tccw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  output logic              done,
  output res_t              result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t              cfg;
  ucode_t            uc;
  flags_t            flags;
  logic              accept;
  logic              pos_ok;

  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col_next;
  logic [ROW_W-1:0]  cur_row_next;
  logic [IDX_W-1:0]  cnt;

  logic [COL_W-1:0]  pcol;
  logic [ROW_W-1:0]  prow;
  logic [7:0]        ch;
  logic [7:0]        eff_attr;
  logic              err;
  logic              rd_flag;

  logic [IDX_W-1:0]  pidx;
  logic [IDX_W-1:0]  cur_idx;
  logic              is_nl;
  logic              is_bs;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W:0]    put_row_ext;
  logic              wrap;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tccw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tccw_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (cmd.op),
    .pos_ok (pos_ok),
    .flags  (flags),
    .uc     (uc),
    .busy   (busy),
    .done   (done)
  );

  tccw_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept = start & ~busy;
  assign pos_ok = (32'(cmd.col) < COLS) && (32'(cmd.row) < ROWS);

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd.op == OP_PUT_CUR) begin
        pcol <= cur_col;
        prow <= cur_row;
      end else begin
        pcol <= COL_W'(cmd.col);
        prow <= ROW_W'(cmd.row);
      end
      ch       <= cmd.char_code;
      eff_attr <= (cmd.attr == 8'd0) ? cfg.default_attr : cmd.attr;
      err      <= ((cmd.op == OP_PUT_AT) || (cmd.op == OP_READ)) && !pos_ok;
      rd_flag  <= (cmd.op == OP_READ) && pos_ok;
    end
  end

  // Linear cell indexes
  assign pidx    = IDX_W'(prow) * IDX_W'(COLS) + IDX_W'(pcol);
  assign cur_idx = IDX_W'(cur_row) * IDX_W'(COLS) + IDX_W'(cur_col);

  // Cursor after a put
  assign is_nl = (ch == CH_NEWLINE);
  assign is_bs = (ch == CH_BLANK_CODE);

  always_comb begin
    if (is_nl) begin
      put_col     = '0;
      put_row_ext = {1'b0, prow} + 1'b1;
    end else if (is_bs) begin
      put_col     = pcol;
      put_row_ext = {1'b0, prow};
    end else if (pcol == COL_W'(COLS - 1)) begin
      put_col     = '0;
      put_row_ext = {1'b0, prow} + 1'b1;
    end else begin
      put_col     = pcol + 1'b1;
      put_row_ext = {1'b0, prow};
    end
    wrap = (put_row_ext == (ROW_W + 1)'(ROWS));
  end

  // Next cursor
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    case (uc.cur)
      CU_PUT: begin
        cur_col_next = put_col;
        cur_row_next = wrap ? ROW_W'(ROWS - 1) : put_row_ext[ROW_W-1:0];
      end
      CU_BACK: begin
        if (cur_col != '0) begin
          cur_col_next = cur_col - 1'b1;
        end else if (cur_row != '0) begin
          cur_col_next = COL_W'(COLS - 1);
          cur_row_next = cur_row - 1'b1;
        end
      end
      CU_ZERO: begin
        cur_col_next = '0;
        cur_row_next = '0;
      end
      default: ;
    endcase
  end

  // Hold cursor and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      cnt     <= '0;
    end else begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      if (accept) begin
        cnt <= '0;
      end else if (uc.cnt == N_INC) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Conditions for the sequencer
  assign flags.wrap       = wrap;
  assign flags.more_copy  = (cnt != IDX_W'(CELLS - COLS - 1));
  assign flags.more_cells = (cnt != IDX_W'(CELLS - 1));

  // Store write port
  always_comb begin
    case (uc.addr)
      A_POS:    mem_waddr = pidx;
      A_CUR:    mem_waddr = cur_idx;
      A_LAST:   mem_waddr = IDX_W'(CELLS - 1);
      A_CNT:    mem_waddr = cnt;
      A_CNT_M1: mem_waddr = cnt - 1'b1;
      default:  mem_waddr = cnt;
    endcase
    case (uc.data)
      D_ZERO:  mem_wdata = '0;
      D_PUT:   mem_wdata = {eff_attr, is_bs ? CH_SPACE : ch};
      D_BLANK: mem_wdata = {cfg.default_attr, CH_SPACE};
      D_ERR:   mem_wdata = {cfg.error_attr, CH_ERROR};
      D_COPY:  mem_wdata = mem_rdata;
      default: mem_wdata = '0;
    endcase
    mem_we = uc.wr & ~((uc.data == D_PUT) & is_nl);
  end

  // Store read port
  always_comb begin
    mem_re = (uc.rd != R_NONE);
    case (uc.rd)
      R_POS:    mem_raddr = pidx;
      R_SCROLL: mem_raddr = cnt + IDX_W'(COLS);
      default:  mem_raddr = pidx;
    endcase
  end

  // Result beat
  assign result.cursor_col = 7'(cur_col);
  assign result.cursor_row = 6'(cur_row);
  assign result.pos_error  = err;
  assign result.cell_char  = rd_flag ? mem_rdata[7:0]  : 8'd0;
  assign result.cell_attr  = rd_flag ? mem_rdata[15:8] : 8'd0;

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but sequencer stayed idle");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst) !busy |-> !mem_we)
    else $error("store written while idle");
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLS) && (32'(cur_row) < ROWS))
    else $error("cursor off screen");

endmodule

`default_nettype wire
